// File: design/brvm_pkg.sv
// brvm_pkg: shared constants of the register machine execute block
// opcodes, set modes, event codes, field widths and parameter defaults
// no dependencies
package brvm_pkg;

   // parameter defaults
   localparam int NUM_REGS_DEF   = 32;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed field widths of the stream payload
   localparam int FUNC_W      = 4;
   localparam int FIELD_W     = 32;
   localparam int SEL_W       = 5;
   localparam int EV_W        = 3;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;

   // opcodes
   localparam logic [FUNC_W-1:0] OP_SET    = 4'd0;
   localparam logic [FUNC_W-1:0] OP_ADD    = 4'd1;
   localparam logic [FUNC_W-1:0] OP_SUB    = 4'd2;
   localparam logic [FUNC_W-1:0] OP_MUL    = 4'd3;
   localparam logic [FUNC_W-1:0] OP_DIV    = 4'd4;
   localparam logic [FUNC_W-1:0] OP_MOD    = 4'd5;
   localparam logic [FUNC_W-1:0] OP_SHOW   = 4'd6;
   localparam logic [FUNC_W-1:0] OP_JUMP   = 4'd7;
   localparam logic [FUNC_W-1:0] OP_NEXTIF = 4'd8;
   localparam logic [FUNC_W-1:0] OP_SKIPIF = 4'd9;
   localparam logic [FUNC_W-1:0] OP_PRINT  = 4'd10;
   localparam logic [FUNC_W-1:0] OP_EXIT   = 4'd11;

   // set modes
   localparam logic [SEL_W-1:0] SET_IMM  = 5'd0;
   localparam logic [SEL_W-1:0] SET_COPY = 5'd1;

   // event codes
   localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EV_W-1:0] EV_SHOW    = 3'd1;
   localparam logic [EV_W-1:0] EV_PRINT   = 3'd2;
   localparam logic [EV_W-1:0] EV_EXIT    = 3'd3;
   localparam logic [EV_W-1:0] EV_DIVZERO = 3'd4;
   localparam logic [EV_W-1:0] EV_ILLEGAL = 3'd5;

endpackage

// File: design/bytecode_register_vm_execute_top.sv
// bytecode_register_vm_execute_top: execute stage of a twelve-opcode register machine
// register file memory, one shared add/sub unit under a small sequencer
// depends on brvm_pkg
//
// sequence: an accepted request is executed in S_EXEC; mul, and div and mod with a
//   nonzero divisor, then iterate in S_ITER (one shift-add or trial subtract per bit)
//   on the shared add/sub unit and write back in S_FIX; S_DONE loads the response register
// a new request is taken only after the previous result has moved into the response
//   register, so one instruction is in flight at a time; while the response slot stays
//   blocked, the block waits in S_DONE
// reset: synchronous; clears the sequencer, the output valid and the register
//   valid bits, so every register reads zero; no clearing pass is needed
module bytecode_register_vm_execute_top #(
   parameter int NUM_REGS   = brvm_pkg::NUM_REGS_DEF,
   parameter int DATA_WIDTH = brvm_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [brvm_pkg::REQ_TDATA_W-1:0]    req_tdata,  // field_a, field_b, field_c
   input  logic [brvm_pkg::FUNC_W-1:0]         req_tuser,  // func
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [brvm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // pc_step, event_value, event_reg
   output logic [brvm_pkg::EV_W-1:0]           rsp_tuser   // event_res
);

   localparam int W  = DATA_WIDTH;
   localparam int AW = $clog2(NUM_REGS);
   localparam int CW = $clog2(DATA_WIDTH);
   localparam int FW = brvm_pkg::FIELD_W;
   localparam int SW = brvm_pkg::SEL_W;
   localparam int EW = brvm_pkg::EV_W;
   localparam logic [FW-1:0] NREG_LIM = FW'(NUM_REGS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ITER,
      S_FIX,
      S_DONE
   } state_type;

   // request fields
   logic [brvm_pkg::FUNC_W-1:0] req_func;
   logic [FW-1:0]               req_fa;
   logic [FW-1:0]               req_fb;
   logic [SW-1:0]               req_fc;

   assign req_func = req_tuser;
   assign req_fa   = req_tdata[FW-1:0];
   assign req_fb   = req_tdata[2*FW-1:FW];
   assign req_fc   = req_tdata[2*FW+SW-1:2*FW];

   // register file with per-entry valid bits
   logic [W-1:0]        mem [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [W-1:0]        wr_data;

   logic                rd0_use_a;
   logic [FW-1:0]       rd0_idx;
   logic                rd0_ok;
   logic                rd1_ok;
   logic [AW-1:0]       rd0_addr;
   logic [AW-1:0]       rd1_addr;
   logic [W-1:0]        rd0_data_ff;
   logic [W-1:0]        rd1_data_ff;
   logic                rd0_hit_ff;
   logic                rd1_hit_ff;

   // port 0 reads the tested register for show and compares, else the first source
   assign rd0_use_a = (req_func == brvm_pkg::OP_SHOW) || (req_func == brvm_pkg::OP_NEXTIF) ||
                      (req_func == brvm_pkg::OP_SKIPIF);
   assign rd0_idx   = rd0_use_a ? req_fa : req_fb;
   assign rd0_ok    = rd0_idx < NREG_LIM;
   assign rd1_ok    = FW'(req_fc) < NREG_LIM;
   assign rd0_addr  = rd0_ok ? rd0_idx[AW-1:0] : '0;
   assign rd1_addr  = rd1_ok ? AW'(req_fc) : '0;

   // memory array: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_data_ff <= mem[rd0_addr];
      rd1_data_ff <= mem[rd1_addr];
      rd0_hit_ff  <= rd0_ok & vld_ff[rd0_addr];
      rd1_hit_ff  <= rd1_ok & vld_ff[rd1_addr];
   end

   // valid bits, an unwritten entry reads zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // sequencer and datapath registers
   state_type                   state_ff, state_in;
   logic [brvm_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [FW-1:0]               fa_ff, fa_in;
   logic [FW-1:0]               fb_ff, fb_in;
   logic [SW-1:0]               fc_ff, fc_in;
   logic                        fa_ok_ff, fa_ok_in;
   logic [W-1:0]                acc_ff, acc_in;
   logic [W-1:0]                aux_ff, aux_in;
   logic [W-1:0]                opnd_ff, opnd_in;
   logic                        neg_ff, neg_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [FW-1:0]               res_step_ff, res_step_in;
   logic [EW-1:0]               res_ev_ff, res_ev_in;
   logic [FW-1:0]               res_val_ff, res_val_in;
   logic [SW-1:0]               res_reg_ff, res_reg_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]               rsp_step_ff, rsp_step_in;
   logic [EW-1:0]               rsp_ev_ff, rsp_ev_in;
   logic [FW-1:0]               rsp_val_ff, rsp_val_in;
   logic [SW-1:0]               rsp_reg_ff, rsp_reg_in;

   // shared add/sub unit
   logic [W:0] add_a;
   logic [W:0] add_b;
   logic       add_sub;
   logic [W:0] add_res;

   assign add_res = add_a + (add_sub ? ~add_b : add_b) + (W+1)'(add_sub);

   // operand views
   logic [W-1:0]        x;
   logic [W-1:0]        y;
   logic signed [63:0]  xs64;
   logic signed [63:0]  fbs64;
   logic                cmp_eq;
   logic [W-1:0]        mx;
   logic [W-1:0]        my;
   logic [W-1:0]        fix_val;

   assign x       = rd0_hit_ff ? rd0_data_ff : '0;
   assign y       = rd1_hit_ff ? rd1_data_ff : '0;
   assign xs64    = 64'(signed'(x));
   assign fbs64   = 64'(signed'(fb_ff));
   assign cmp_eq  = (xs64 == fbs64);
   assign mx      = x[W-1] ? (~x + W'(1)) : x;
   assign my      = y[W-1] ? (~y + W'(1)) : y;
   assign fix_val = (func_ff == brvm_pkg::OP_DIV) ? aux_ff : acc_ff;
   assign wr_addr = fa_ff[AW-1:0];

   // next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      fc_in        = fc_ff;
      fa_ok_in     = fa_ok_ff;
      acc_in       = acc_ff;
      aux_in       = aux_ff;
      opnd_in      = opnd_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      res_step_in  = res_step_ff;
      res_ev_in    = res_ev_ff;
      res_val_in   = res_val_ff;
      res_reg_in   = res_reg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_step_in  = rsp_step_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_reg_in   = rsp_reg_ff;
      add_a        = '0;
      add_b        = '0;
      add_sub      = 1'b0;
      wr_en        = 1'b0;
      wr_data      = add_res[W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_func;
               fa_in    = req_fa;
               fb_in    = req_fb;
               fc_in    = req_fc;
               fa_ok_in = req_fa < NREG_LIM;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_step_in = FW'(1);
            res_ev_in   = brvm_pkg::EV_NONE;
            res_val_in  = '0;
            res_reg_in  = '0;
            state_in    = S_DONE;
            unique case (func_ff) inside
               brvm_pkg::OP_SET: begin
                  if (fc_ff == brvm_pkg::SET_IMM) begin
                     wr_en   = fa_ok_ff;
                     wr_data = fbs64[W-1:0];
                  end else if (fc_ff == brvm_pkg::SET_COPY) begin
                     wr_en   = fa_ok_ff;
                     wr_data = x;
                  end
               end
               brvm_pkg::OP_ADD, brvm_pkg::OP_SUB: begin
                  add_a   = {1'b0, x};
                  add_b   = {1'b0, y};
                  add_sub = (func_ff == brvm_pkg::OP_SUB);
                  wr_en   = fa_ok_ff;
                  wr_data = add_res[W-1:0];
               end
               brvm_pkg::OP_MUL: begin
                  acc_in   = '0;
                  aux_in   = x;
                  opnd_in  = y;
                  neg_in   = 1'b0;
                  cnt_in   = CW'(DATA_WIDTH - 1);
                  state_in = S_ITER;
               end
               brvm_pkg::OP_DIV, brvm_pkg::OP_MOD: begin
                  if (y == '0) begin
                     res_ev_in   = brvm_pkg::EV_DIVZERO;
                     res_step_in = '0;
                  end else begin
                     acc_in   = '0;
                     aux_in   = mx;
                     opnd_in  = my;
                     neg_in   = (func_ff == brvm_pkg::OP_DIV) ? (x[W-1] ^ y[W-1]) : x[W-1];
                     cnt_in   = CW'(DATA_WIDTH - 1);
                     state_in = S_ITER;
                  end
               end
               brvm_pkg::OP_SHOW: begin
                  res_ev_in  = brvm_pkg::EV_SHOW;
                  res_val_in = xs64[FW-1:0];
                  res_reg_in = fa_ff[SW-1:0];
               end
               brvm_pkg::OP_JUMP: begin
                  res_step_in = fa_ff;
               end
               brvm_pkg::OP_NEXTIF: begin
                  res_step_in = cmp_eq ? FW'(1) : FW'(2);
               end
               brvm_pkg::OP_SKIPIF: begin
                  res_step_in = cmp_eq ? FW'(2) : FW'(1);
               end
               brvm_pkg::OP_PRINT: begin
                  res_ev_in  = brvm_pkg::EV_PRINT;
                  res_val_in = fa_ff;
               end
               brvm_pkg::OP_EXIT: begin
                  res_ev_in   = brvm_pkg::EV_EXIT;
                  res_val_in  = fa_ff;
                  res_step_in = '0;
               end
               default: begin
                  res_ev_in   = brvm_pkg::EV_ILLEGAL;
                  res_step_in = '0;
               end
            endcase
         end
         S_ITER: begin
            if (func_ff == brvm_pkg::OP_MUL) begin
               // shift-add, one multiplier bit per cycle
               add_a   = {1'b0, acc_ff};
               add_b   = {1'b0, aux_ff};
               if (opnd_ff[0]) begin
                  acc_in = add_res[W-1:0];
               end
               aux_in  = {aux_ff[W-2:0], 1'b0};
               opnd_in = {1'b0, opnd_ff[W-1:1]};
            end else begin
               // restoring divide, one quotient bit per cycle
               add_a   = {acc_ff, aux_ff[W-1]};
               add_b   = {1'b0, opnd_ff};
               add_sub = 1'b1;
               acc_in  = add_res[W] ? add_a[W-1:0] : add_res[W-1:0];
               aux_in  = {aux_ff[W-2:0], ~add_res[W]};
            end
            if (cnt_ff == '0) begin
               state_in = S_FIX;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         S_FIX: begin
            // sign correction and write back
            add_a    = '0;
            add_b    = {1'b0, fix_val};
            add_sub  = 1'b1;
            wr_en    = fa_ok_ff;
            wr_data  = neg_ff ? add_res[W-1:0] : fix_val;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_step_in  = res_step_ff;
               rsp_ev_in    = res_ev_ff;
               rsp_val_in   = res_val_ff;
               rsp_reg_in   = res_reg_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      fc_ff       <= fc_in;
      fa_ok_ff    <= fa_ok_in;
      acc_ff      <= acc_in;
      aux_ff      <= aux_in;
      opnd_ff     <= opnd_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      res_step_ff <= res_step_in;
      res_ev_ff   <= res_ev_in;
      res_val_ff  <= res_val_in;
      res_reg_ff  <= res_reg_in;
      rsp_step_ff <= rsp_step_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_reg_ff  <= rsp_reg_in;
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tdata  = {{(brvm_pkg::RSP_TDATA_W - 2*FW - SW){1'b0}},
                        rsp_reg_ff, rsp_val_ff, rsp_step_ff};

   // checks
   a_wr_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_EXEC || state_ff == S_FIX))
      else $error("register file written outside execute or fix phase");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted transfer did not enter execute");

   a_divzero_nowrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && (func_ff == brvm_pkg::OP_DIV || func_ff == brvm_pkg::OP_MOD) &&
       y == '0) |-> (!wr_en && state_in == S_DONE))
      else $error("divide by zero changed a register or started iterating");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_DONE))
      else $error("finished result left before output slot freed");

endmodule

// File: tb/bytecode_register_vm_execute_top_tb.sv
// testbench for bytecode_register_vm_execute_top: directed and random instruction streams
// checked against an in-bench model of the register file and the twelve opcodes
// depends on brvm_pkg and the execute block RTL
`timescale 1ns / 100ps

module bytecode_register_vm_execute_top_tb;

   localparam logic [brvm_pkg::FUNC_W-1:0] OP_FIRST_ILLEGAL = brvm_pkg::OP_EXIT + 4'd1;
   localparam logic [brvm_pkg::FUNC_W-1:0] OP_LAST_ILLEGAL  = '1;
   localparam int RANDOM_INSTRS = 1525;

   // one decoded instruction, plus a flag that holds it back until the block drains
   typedef struct packed {
      logic [brvm_pkg::FUNC_W-1:0]  func;
      logic [brvm_pkg::FIELD_W-1:0] opd_a;
      logic [brvm_pkg::FIELD_W-1:0] opd_b;
      logic [brvm_pkg::SEL_W-1:0]   opd_c;
      logic                         wait_idle;
   } vm_instr_type;

   // one execute outcome
   typedef struct packed {
      logic [brvm_pkg::FIELD_W-1:0] pc_step;
      logic [brvm_pkg::EV_W-1:0]    ev;
      logic [brvm_pkg::FIELD_W-1:0] ev_value;
      logic [brvm_pkg::SEL_W-1:0]   ev_reg;
   } vm_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [brvm_pkg::REQ_TDATA_W-1:0] req_tdata = '0;  // field_a, field_b, field_c
   logic [brvm_pkg::FUNC_W-1:0]      req_tuser = '0;  // func
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [brvm_pkg::RSP_TDATA_W-1:0] rsp_tdata;       // pc_step, event_value, event_reg
   logic [brvm_pkg::EV_W-1:0]        rsp_tuser;       // event_res

   vm_instr_type   pending_q[$];
   vm_outcome_type outcome_q[$];
   vm_instr_type   active_instr;
   logic [brvm_pkg::FIELD_W-1:0] gpr_model [0:31] = '{default: '0};
   int error_count    = 0;
   int accepted_count = 0;
   int total_instrs   = 0;
   int burst_left     = 1;
   int gap_left       = 0;

   bytecode_register_vm_execute_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // out-of-range indexes, negative ones included, read as zero
   function automatic logic [brvm_pkg::FIELD_W-1:0] gpr_read(
         logic [brvm_pkg::FIELD_W-1:0] idx);
      return (idx < 32) ? gpr_model[idx[4:0]] : '0;
   endfunction

   // apply one instruction to the model register file and return its outcome
   function automatic vm_outcome_type execute_instr(vm_instr_type ins);
      vm_outcome_type res;
      logic [brvm_pkg::FIELD_W-1:0] src_x, src_y, mag_x, mag_y, quot;
      logic                         wr_en;
      logic [brvm_pkg::FIELD_W-1:0] wr_val;
      src_x    = gpr_read(ins.opd_b);
      src_y    = gpr_model[ins.opd_c];
      res      = '0;
      res.pc_step = 1;
      res.ev   = brvm_pkg::EV_NONE;
      wr_en    = 1'b0;
      wr_val   = '0;
      case (ins.func)
         brvm_pkg::OP_SET: begin
            if (ins.opd_c == brvm_pkg::SET_IMM) begin
               wr_en = 1'b1; wr_val = ins.opd_b;
            end else if (ins.opd_c == brvm_pkg::SET_COPY) begin
               wr_en = 1'b1; wr_val = src_x;
            end
         end
         brvm_pkg::OP_ADD: begin wr_en = 1'b1; wr_val = src_x + src_y; end
         brvm_pkg::OP_SUB: begin wr_en = 1'b1; wr_val = src_x - src_y; end
         brvm_pkg::OP_MUL: begin wr_en = 1'b1; wr_val = src_x * src_y; end
         brvm_pkg::OP_DIV, brvm_pkg::OP_MOD: begin
            if (src_y == '0) begin
               res.ev = brvm_pkg::EV_DIVZERO;
               res.pc_step = 0;
            end else begin
               // work on magnitudes, then fix the sign (truncating division)
               mag_x = src_x[brvm_pkg::FIELD_W-1] ? ('0 - src_x) : src_x;
               mag_y = src_y[brvm_pkg::FIELD_W-1] ? ('0 - src_y) : src_y;
               if (ins.func == brvm_pkg::OP_DIV) begin
                  quot = mag_x / mag_y;
                  if (src_x[brvm_pkg::FIELD_W-1] != src_y[brvm_pkg::FIELD_W-1]) quot = '0 - quot;
               end else begin
                  quot = mag_x % mag_y;
                  if (src_x[brvm_pkg::FIELD_W-1]) quot = '0 - quot;
               end
               wr_en = 1'b1; wr_val = quot;
            end
         end
         brvm_pkg::OP_SHOW: begin
            res.ev       = brvm_pkg::EV_SHOW;
            res.ev_value = gpr_read(ins.opd_a);
            res.ev_reg   = ins.opd_a[4:0];
         end
         brvm_pkg::OP_JUMP: res.pc_step = ins.opd_a;
         brvm_pkg::OP_NEXTIF: res.pc_step = (gpr_read(ins.opd_a) == ins.opd_b) ? 1 : 2;
         brvm_pkg::OP_SKIPIF: res.pc_step = (gpr_read(ins.opd_a) == ins.opd_b) ? 2 : 1;
         brvm_pkg::OP_PRINT: begin
            res.ev = brvm_pkg::EV_PRINT; res.ev_value = ins.opd_a;
         end
         brvm_pkg::OP_EXIT: begin
            res.ev = brvm_pkg::EV_EXIT; res.ev_value = ins.opd_a; res.pc_step = 0;
         end
         default: begin
            res.ev = brvm_pkg::EV_ILLEGAL; res.pc_step = 0;
         end
      endcase
      if (wr_en && ins.opd_a < 32) gpr_model[ins.opd_a[4:0]] = wr_val;
      return res;
   endfunction

   task automatic queue_instr(logic [brvm_pkg::FUNC_W-1:0] func,
                              logic [brvm_pkg::FIELD_W-1:0] a,
                              logic [brvm_pkg::FIELD_W-1:0] b,
                              logic [brvm_pkg::SEL_W-1:0] c, logic hold);
      vm_instr_type ins;
      ins.func = func; ins.opd_a = a; ins.opd_b = b; ins.opd_c = c; ins.wait_idle = hold;
      pending_q.push_back(ins);
   endtask

   // mostly valid register numbers, sometimes far out of range
   function automatic logic [brvm_pkg::FIELD_W-1:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88) return $urandom_range(0, 31);
      else if (r < 94) return $urandom_range(32, 1000);
      return $urandom();
   endfunction

   // values that are likely to collide, plus corner values and noise
   function automatic logic [brvm_pkg::FIELD_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(0, 20);
         6: return 32'd0 - $urandom_range(1, 20);
         default: return $urandom();
      endcase
   endfunction

   // request driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin : drive_requests
      vm_instr_type next_instr;
      logic         offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(execute_instr(active_instr));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].wait_idle && outcome_q.size() != 0)) begin
               next_instr   = pending_q.pop_front();
               active_instr = next_instr;
               offer        = 1'b1;
               req_tdata <= {3'b000, next_instr.opd_c, next_instr.opd_b, next_instr.opd_a};
               req_tuser <= next_instr.func;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
            req_tvalid <= offer;
         end
      end
   end

   // response ready: changing stall patterns, plus two long hold-offs
   int          ready_cycle   = 0;
   int          holdoff_left  = 0;
   int          stall_mode    = 0;
   logic [15:0] ready_mask    = '1;

   always @(posedge clock) begin : drive_ready
      ready_cycle++;
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else if (ready_cycle == 2000 || ready_cycle == 12000) begin
         holdoff_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         if (ready_cycle % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
            ready_mask = $urandom();
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ready_mask[ready_cycle % 16];
            2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= $urandom_range(0, 1);
         endcase
      end
   end

   // response monitor: compare every transfer with the oldest outcome
   always @(posedge clock) begin : check_responses
      vm_outcome_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pc_step  = rsp_tdata[31:0];
         got.ev_value = rsp_tdata[63:32];
         got.ev_reg   = rsp_tdata[68:64];
         got.ev       = rsp_tuser;
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected response, pc_step %h event %0d value %h reg %0d",
                     $time, got.pc_step, got.ev, got.ev_value, got.ev_reg);
            error_count++;
         end else begin
            want = outcome_q.pop_front();
            if (got.pc_step !== want.pc_step) begin
               $display("%0t: pc_step expected %h actual %h", $time, want.pc_step, got.pc_step);
               error_count++;
            end
            if (got.ev !== want.ev) begin
               $display("%0t: event_res expected %0d actual %0d", $time, want.ev, got.ev);
               error_count++;
            end
            if (got.ev_value !== want.ev_value) begin
               $display("%0t: event_value expected %h actual %h",
                        $time, want.ev_value, got.ev_value);
               error_count++;
            end
            if (got.ev_reg !== want.ev_reg) begin
               $display("%0t: event_reg expected %0d actual %0d", $time, want.ev_reg, got.ev_reg);
               error_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int sel;
      logic [brvm_pkg::FUNC_W-1:0] op;
      logic [brvm_pkg::SEL_W-1:0]  mode;
      logic                        hold;

      // corner values into the first registers, set modes and index edges
      queue_instr(brvm_pkg::OP_SET, 0, 32'h7FFF_FFFF, brvm_pkg::SET_IMM, 1'b0);
      queue_instr(brvm_pkg::OP_SET, 1, 32'h8000_0000, brvm_pkg::SET_IMM, 1'b0);
      queue_instr(brvm_pkg::OP_SET, 2, 32'hFFFF_FFFF, brvm_pkg::SET_IMM, 1'b0);
      queue_instr(brvm_pkg::OP_SET, 3, 1, brvm_pkg::SET_COPY, 1'b0);
      // unknown mode
      queue_instr(brvm_pkg::OP_SET, 4, 5, brvm_pkg::SET_COPY + 5'd1, 1'b0);
      // write past the file
      queue_instr(brvm_pkg::OP_SET, 40, 32'h1234_5678, brvm_pkg::SET_IMM, 1'b0);
      // copy from negative index
      queue_instr(brvm_pkg::OP_SET, 3, 32'hFFFF_FFFF, brvm_pkg::SET_COPY, 1'b0);
      // wrapping arithmetic
      queue_instr(brvm_pkg::OP_ADD, 6, 0, 5'd1, 1'b0);
      queue_instr(brvm_pkg::OP_ADD, 7, 0, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_SUB, 8, 1, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_MUL, 9, 0, 5'd2, 1'b0);
      queue_instr(brvm_pkg::OP_MUL, 10, 1, 5'd1, 1'b0);
      // most negative over minus one, negative dividends, zero divisors
      queue_instr(brvm_pkg::OP_DIV, 11, 1, 5'd2, 1'b0);
      queue_instr(brvm_pkg::OP_MOD, 12, 1, 5'd2, 1'b0);
      queue_instr(brvm_pkg::OP_DIV, 13, 1, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_MOD, 14, 1, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_DIV, 15, 0, 5'd20, 1'b0);
      queue_instr(brvm_pkg::OP_MOD, 16, 2, 5'd31, 1'b0);
      // events and control flow
      queue_instr(brvm_pkg::OP_SHOW, 1, 0, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_SHOW, 32'hFFFF_FFFF, 0, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_JUMP, 32'h8000_0000, 0, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_NEXTIF, 2, 32'hFFFF_FFFF, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_SKIPIF, 2, 32'hFFFF_FFFF, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_NEXTIF, 0, 0, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_PRINT, 32'hFFFF_FFFF, 0, 5'd0, 1'b0);
      queue_instr(brvm_pkg::OP_EXIT, 32'h7FFF_FFFF, 0, 5'd0, 1'b0);
      queue_instr(OP_FIRST_ILLEGAL, 3, 3, 5'd3, 1'b0);
      queue_instr(OP_LAST_ILLEGAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1'b0);

      // random program, weighted toward register traffic
      for (int i = 0; i < RANDOM_INSTRS; i++) begin
         hold = ((i % 250) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 24) begin
            sel = $urandom_range(0, 9);
            mode = (sel < 5) ? brvm_pkg::SET_IMM : (sel < 9) ? brvm_pkg::SET_COPY :
                   5'($urandom_range(2, 31));
            queue_instr(brvm_pkg::OP_SET, pick_index(),
                        (mode == brvm_pkg::SET_IMM) ? pick_value() : pick_index(),
                        mode, hold);
         end else if (sel < 69) begin
            op = (sel < 34) ? brvm_pkg::OP_ADD : (sel < 42) ? brvm_pkg::OP_SUB :
                 (sel < 50) ? brvm_pkg::OP_MUL : (sel < 60) ? brvm_pkg::OP_DIV :
                 brvm_pkg::OP_MOD;
            queue_instr(op, pick_index(), pick_index(), 5'($urandom_range(0, 31)), hold);
         end else if (sel < 75) begin
            queue_instr(brvm_pkg::OP_SHOW, pick_index(), $urandom(),
                        5'($urandom_range(0, 31)), hold);
         end else if (sel < 80) begin
            queue_instr(brvm_pkg::OP_JUMP, pick_value(), $urandom(),
                        5'($urandom_range(0, 31)), hold);
         end else if (sel < 92) begin
            op = (sel < 86) ? brvm_pkg::OP_NEXTIF : brvm_pkg::OP_SKIPIF;
            queue_instr(op, pick_index(), pick_value(), 5'($urandom_range(0, 31)), hold);
         end else if (sel < 98) begin
            op = (sel < 95) ? brvm_pkg::OP_PRINT : brvm_pkg::OP_EXIT;
            queue_instr(op, $urandom(), $urandom(), 5'($urandom_range(0, 31)), hold);
         end else begin
            op = OP_FIRST_ILLEGAL + 4'($urandom_range(0, 3));
            queue_instr(op, $urandom(), $urandom(), 5'($urandom_range(0, 31)), hold);
         end
      end
      total_instrs = pending_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_instrs) @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (outcome_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, outcome_q.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sim.f
design/brvm_pkg.sv
design/bytecode_register_vm_execute_top.sv
tb/bytecode_register_vm_execute_top_tb.sv
